>>> rtl/eorq_pkg.sv
// ----------------------------------------------------------------------------
// eorq_pkg
// Shared types and codes for the elevator order rank queue.
// ----------------------------------------------------------------------------
package eorq_pkg;

  localparam int unsigned FLOOR_W = 2;
  localparam int unsigned RANK_W  = 4;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  typedef enum logic [1:0] {
    MODE_PLACE     = 2'd0,
    MODE_CLEAR     = 2'd1,
    MODE_SCAN_UP   = 2'd2,
    MODE_SCAN_DOWN = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    BTN_UP   = 2'd0,
    BTN_DOWN = 2'd1,
    BTN_CAB  = 2'd2,
    BTN_NONE = 2'd3
  } button_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_PRE    = 2'd1,
    ST_SWEEP  = 2'd2,
    ST_FINISH = 2'd3
  } state_e;

  typedef struct packed {
    logic [RANK_W-1:0] cab;
    logic [RANK_W-1:0] down;
    logic [RANK_W-1:0] up;
  } entry_t;

endpackage

>>> rtl/elevator_order_rank_queue.sv
// ----------------------------------------------------------------------------
// elevator_order_rank_queue: per-floor order ranks kept in one entry memory
// Each transaction is a read-modify-write sweep through the entry memory, one floor
// per cycle; a clear of an in-range floor first reads that floor's entry. A new
// transaction is taken only after the last result is loaded into the output register.
// Reset: per-entry valid bits clear at once, so all entries read as no order.
// ----------------------------------------------------------------------------
module elevator_order_rank_queue #(
  parameter int unsigned FLOORS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     mode_i,
  input  logic [eorq_pkg::FLOOR_W-1:0]   floor_i,
  input  logic [1:0]                     button_i,
  input  logic [eorq_pkg::FLOOR_W-1:0]   current_floor_i,
  input  logic [eorq_pkg::FLOOR_W-1:0]   destination_floor_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [eorq_pkg::FLOOR_W-1:0]   next_floor_o,
  output logic                           next_valid_o,
  output logic [eorq_pkg::FLOOR_W-1:0]   stop_floor_o,
  output logic [eorq_pkg::RANK_W-1:0]    active_count_o
);

  localparam int unsigned IDXW = (FLOORS > 1) ? $clog2(FLOORS) : 1;
  localparam int unsigned CW   = IDXW + eorq_pkg::FLOOR_W;
  localparam int unsigned RW   = eorq_pkg::RANK_W;

  eorq_pkg::state_e state_q, state_d;

  eorq_pkg::entry_t mem [FLOORS];
  logic [FLOORS-1:0] vld_q;
  eorq_pkg::entry_t  rdata_q;
  logic              rvld_q;
  logic [IDXW-1:0]   rd_addr;
  logic              wr_en;
  eorq_pkg::entry_t  wr_data;

  eorq_pkg::mode_e   mode_q;
  logic [CW-1:0]     floor_q, cur_q, dst_q;
  logic [1:0]        button_q;
  logic [IDXW-1:0]   idx_q, idx_d;
  eorq_pkg::entry_t  thr_q, thr_d;
  logic [RW-1:0]     count_q, count_d;
  logic [CW-1:0]     nf_q, nf_d, stop_q, stop_d;
  logic              nv_q, nv_d, found_q, found_d;

  logic              out_valid_q;
  logic [eorq_pkg::FLOOR_W-1:0] next_floor_q, stop_floor_q;
  logic              next_valid_q;
  logic [RW-1:0]     active_count_q;

  logic              in_fire;
  logic              out_free;
  logic              load_out;
  logic              last_idx;
  logic [CW-1:0]     floor_ext, idx_ext;
  eorq_pkg::entry_t  ent;
  logic [1:0]        removed;

  function automatic logic [RW-1:0] lower_rank(logic [RW-1:0] r, eorq_pkg::entry_t t);
    logic [1:0] dec;
    dec = {1'b0, (t.up != '0) && (t.up < r)}
        + {1'b0, (t.down != '0) && (t.down < r)}
        + {1'b0, (t.cab != '0) && (t.cab < r)};
    return (r == '0) ? r : r - {{(RW-2){1'b0}}, dec};
  endfunction

  assign in_stall_o = (state_q != eorq_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign floor_ext  = {{IDXW{1'b0}}, floor_i};
  assign idx_ext    = {{eorq_pkg::FLOOR_W{1'b0}}, idx_q};
  assign last_idx   = (idx_q == IDXW'(FLOORS - 1));
  assign ent        = rvld_q ? rdata_q : '0;
  assign removed    = {1'b0, ent.up != '0} + {1'b0, ent.down != '0}
                    + {1'b0, ent.cab != '0};

  always_comb begin
    state_d = state_q;
    case (state_q)
      eorq_pkg::ST_IDLE: begin
        if (in_fire) begin
          if ((mode_i == eorq_pkg::MODE_CLEAR) && (floor_ext < CW'(FLOORS))) begin
            state_d = eorq_pkg::ST_PRE;
          end else begin
            state_d = eorq_pkg::ST_SWEEP;
          end
        end
      end
      eorq_pkg::ST_PRE: begin
        state_d = eorq_pkg::ST_SWEEP;
      end
      eorq_pkg::ST_SWEEP: begin
        if (last_idx) begin
          state_d = eorq_pkg::ST_FINISH;
        end
      end
      eorq_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = eorq_pkg::ST_IDLE;
        end
      end
      default: state_d = eorq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_data  = ent;
    idx_d    = idx_q;
    thr_d    = thr_q;
    count_d  = count_q;
    nf_d     = nf_q;
    nv_d     = nv_q;
    stop_d   = stop_q;
    found_d  = found_q;
    load_out = 1'b0;
    case (state_q)
      eorq_pkg::ST_IDLE: begin
        thr_d   = '0;
        idx_d   = '0;
        nf_d    = '0;
        nv_d    = 1'b0;
        found_d = 1'b0;
        stop_d  = ((mode_i == eorq_pkg::MODE_SCAN_UP) ||
                   (mode_i == eorq_pkg::MODE_SCAN_DOWN)) ?
                  {{IDXW{1'b0}}, destination_floor_i} : '0;
        if (in_fire && (mode_i == eorq_pkg::MODE_CLEAR) && (floor_ext < CW'(FLOORS))) begin
          rd_addr = floor_ext[IDXW-1:0];
        end
      end
      eorq_pkg::ST_PRE: begin
        thr_d   = ent;
        count_d = (count_q >= {{(RW-2){1'b0}}, removed}) ?
                  count_q - {{(RW-2){1'b0}}, removed} : '0;
      end
      eorq_pkg::ST_SWEEP: begin
        wr_en = 1'b1;
        case (mode_q)
          eorq_pkg::MODE_PLACE: begin
            if ((idx_ext == floor_q) && (count_q < eorq_pkg::RANK_MAX)) begin
              case (button_q)
                eorq_pkg::BTN_UP: begin
                  if (ent.up == '0) begin
                    wr_data.up = count_q + 1'b1;
                    count_d    = count_q + 1'b1;
                  end
                end
                eorq_pkg::BTN_DOWN: begin
                  if (ent.down == '0) begin
                    wr_data.down = count_q + 1'b1;
                    count_d      = count_q + 1'b1;
                  end
                end
                eorq_pkg::BTN_CAB: begin
                  if (ent.cab == '0) begin
                    wr_data.cab = count_q + 1'b1;
                    count_d     = count_q + 1'b1;
                  end
                end
                default: wr_data = ent;
              endcase
            end
          end
          eorq_pkg::MODE_CLEAR: begin
            if (idx_ext == floor_q) begin
              wr_data = '0;
            end else begin
              wr_data.up   = lower_rank(ent.up, thr_q);
              wr_data.down = lower_rank(ent.down, thr_q);
              wr_data.cab  = lower_rank(ent.cab, thr_q);
            end
          end
          eorq_pkg::MODE_SCAN_UP: begin
            if (!found_q && (idx_ext > cur_q) && (idx_ext < dst_q) &&
                ((ent.up != '0) || (ent.cab != '0))) begin
              stop_d  = idx_ext;
              found_d = 1'b1;
            end
          end
          eorq_pkg::MODE_SCAN_DOWN: begin
            if ((idx_ext < cur_q) && (idx_ext > dst_q) &&
                ((ent.down != '0) || (ent.cab != '0))) begin
              stop_d = idx_ext;
            end
          end
          default: wr_data = ent;
        endcase
        if (!nv_q && ((wr_data.up == RW'(1)) || (wr_data.down == RW'(1)) ||
                      (wr_data.cab == RW'(1)))) begin
          nf_d = idx_ext;
          nv_d = 1'b1;
        end
        if (!last_idx) begin
          idx_d   = idx_q + 1'b1;
          rd_addr = idx_q + 1'b1;
        end
      end
      eorq_pkg::ST_FINISH: begin
        load_out = out_free;
      end
      default: load_out = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx_q] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[rd_addr];
      if (wr_en) begin
        vld_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= eorq_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q   <= eorq_pkg::mode_e'(mode_i);
      floor_q  <= {{IDXW{1'b0}}, floor_i};
      button_q <= button_i;
      cur_q    <= {{IDXW{1'b0}}, current_floor_i};
      dst_q    <= {{IDXW{1'b0}}, destination_floor_i};
    end
    idx_q   <= idx_d;
    thr_q   <= thr_d;
    nf_q    <= nf_d;
    nv_q    <= nv_d;
    stop_q  <= stop_d;
    found_q <= found_d;
    if (load_out) begin
      next_floor_q   <= nf_q[eorq_pkg::FLOOR_W-1:0];
      next_valid_q   <= nv_q;
      stop_floor_q   <= stop_q[eorq_pkg::FLOOR_W-1:0];
      active_count_q <= count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign next_floor_o   = next_floor_q;
  assign next_valid_o   = next_valid_q;
  assign stop_floor_o   = stop_floor_q;
  assign active_count_o = active_count_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: elevator_order_rank_queue
// Drives place, clear and scan transactions through the valid/stall input and
// checks every result against a rank-table model held in a scoreboard. A
// directed opening fills the tables, clears floors 0 and 3 and hits the scan corner cases.
// A long random run follows with idle and stall bursts and one long output
// hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FLOORS     = 4;
  localparam int RAND_ITEMS = 1250;
  localparam int CALM_AFTER = 1100;

  class rank_scoreboard;
    typedef struct {
      logic [eorq_pkg::FLOOR_W-1:0] next_floor;
      logic                         next_valid;
      logic [eorq_pkg::FLOOR_W-1:0] stop_floor;
      logic [eorq_pkg::RANK_W-1:0]  active_count;
    } status_t;

    logic [eorq_pkg::RANK_W-1:0] rank_tbl[3][FLOORS];
    logic [eorq_pkg::RANK_W-1:0] order_count;
    status_t                     expected_status[$];
    int                          mismatches;
    int                          checked;
    int                          peak_count;

    function new();
      foreach (rank_tbl[b, f]) rank_tbl[b][f] = '0;
      order_count = '0;
      mismatches  = 0;
      checked     = 0;
      peak_count  = 0;
    endfunction

    function void drop_order(int b, int f);
      logic [eorq_pkg::RANK_W-1:0] thr;
      thr = rank_tbl[b][f];
      rank_tbl[b][f] = '0;
      if (order_count != 0) order_count--;
      foreach (rank_tbl[i, j]) begin
        if (rank_tbl[i][j] > thr) rank_tbl[i][j]--;
      end
    endfunction

    function void note_request(eorq_pkg::mode_e m, logic [1:0] fl, eorq_pkg::button_e btn,
                               logic [1:0] cur, logic [1:0] dst);
      status_t st;
      int      f;
      bit      hit;
      st.stop_floor = '0;
      case (m)
        eorq_pkg::MODE_PLACE: begin
          if (btn != eorq_pkg::BTN_NONE && int'(fl) < FLOORS &&
              rank_tbl[int'(btn)][fl] == 0 && order_count < eorq_pkg::RANK_MAX) begin
            order_count++;
            rank_tbl[int'(btn)][fl] = order_count;
          end
        end
        eorq_pkg::MODE_CLEAR: begin
          if (int'(fl) < FLOORS) begin
            if (rank_tbl[eorq_pkg::BTN_UP][fl] != 0) drop_order(eorq_pkg::BTN_UP, fl);
            if (rank_tbl[eorq_pkg::BTN_DOWN][fl] != 0) drop_order(eorq_pkg::BTN_DOWN, fl);
            if (rank_tbl[eorq_pkg::BTN_CAB][fl] != 0) drop_order(eorq_pkg::BTN_CAB, fl);
          end
        end
        eorq_pkg::MODE_SCAN_UP: begin
          st.stop_floor = dst;
          hit = 0;
          for (f = int'(cur) + 1; f < int'(dst) && !hit; f++) begin
            if (f < FLOORS && (rank_tbl[eorq_pkg::BTN_UP][f] != 0 ||
                               rank_tbl[eorq_pkg::BTN_CAB][f] != 0)) begin
              st.stop_floor = f[1:0];
              hit = 1;
            end
          end
        end
        default: begin
          st.stop_floor = dst;
          hit = 0;
          for (f = int'(cur) - 1; f > int'(dst) && !hit; f--) begin
            if (f < FLOORS && (rank_tbl[eorq_pkg::BTN_DOWN][f] != 0 ||
                               rank_tbl[eorq_pkg::BTN_CAB][f] != 0)) begin
              st.stop_floor = f[1:0];
              hit = 1;
            end
          end
        end
      endcase

      st.next_floor = '0;
      st.next_valid = 1'b0;
      for (f = 0; f < FLOORS && !st.next_valid; f++) begin
        if (rank_tbl[eorq_pkg::BTN_UP][f] == 1 || rank_tbl[eorq_pkg::BTN_DOWN][f] == 1 ||
            rank_tbl[eorq_pkg::BTN_CAB][f] == 1) begin
          st.next_floor = f[1:0];
          st.next_valid = 1'b1;
        end
      end
      st.active_count = order_count;
      if (int'(order_count) > peak_count) peak_count = order_count;
      expected_status.push_back(st);
    endfunction

    function void check_status(logic [eorq_pkg::FLOOR_W-1:0] nf, logic nv,
                               logic [eorq_pkg::FLOOR_W-1:0] sf,
                               logic [eorq_pkg::RANK_W-1:0] ac);
      status_t st;
      if (expected_status.size() == 0) begin
        $error("result with no transaction pending: next_floor %0d stop_floor %0d count %0d",
               nf, sf, ac);
        mismatches++;
        return;
      end
      st = expected_status.pop_front();
      checked++;
      if (nf !== st.next_floor) begin
        $error("next_floor: expected %0d, actual %0d", st.next_floor, nf);
        mismatches++;
      end
      if (nv !== st.next_valid) begin
        $error("next_valid: expected %0d, actual %0d", st.next_valid, nv);
        mismatches++;
      end
      if (sf !== st.stop_floor) begin
        $error("stop_floor: expected %0d, actual %0d", st.stop_floor, sf);
        mismatches++;
      end
      if (ac !== st.active_count) begin
        $error("active_count: expected %0d, actual %0d", st.active_count, ac);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [1:0]                    mode_i;
  logic [eorq_pkg::FLOOR_W-1:0]  floor_i;
  logic [1:0]                    button_i;
  logic [eorq_pkg::FLOOR_W-1:0]  current_floor_i;
  logic [eorq_pkg::FLOOR_W-1:0]  destination_floor_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [eorq_pkg::FLOOR_W-1:0]  next_floor_o;
  logic                          next_valid_o;
  logic [eorq_pkg::FLOOR_W-1:0]  stop_floor_o;
  logic [eorq_pkg::RANK_W-1:0]   active_count_o;

  rank_scoreboard board = new();
  int  accepted       = 0;
  int  stalled_cycles = 0;
  int  mode_seen[4]   = '{0, 0, 0, 0};
  bit  calm           = 0;

  elevator_order_rank_queue #(.FLOORS(FLOORS)) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .mode_i              (mode_i),
    .floor_i             (floor_i),
    .button_i            (button_i),
    .current_floor_i     (current_floor_i),
    .destination_floor_i (destination_floor_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .next_floor_o        (next_floor_o),
    .next_valid_o        (next_valid_o),
    .stop_floor_o        (stop_floor_o),
    .active_count_o      (active_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic pause_sender(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_request(eorq_pkg::mode_e m, logic [1:0] fl, eorq_pkg::button_e btn,
                              logic [1:0] cur, logic [1:0] dst);
    if (!calm && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 3));
    in_valid_i          <= 1'b1;
    mode_i              <= m;
    floor_i             <= fl;
    button_i            <= btn;
    current_floor_i     <= cur;
    destination_floor_i <= dst;
    @(posedge clk_i);
    while (in_stall_o) begin
      stalled_cycles++;
      @(posedge clk_i);
    end
    board.note_request(m, fl, btn, cur, dst);
    accepted++;
    mode_seen[int'(m)]++;
  endtask

  // receiver: random stall bursts, one long hold-off, quiet at the end
  initial begin
    int burst;
    int hold;
    bit held;
    burst = 0;
    hold  = 0;
    held  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        board.check_status(next_floor_o, next_valid_o, stop_floor_o, active_count_o);
      if (!held && accepted >= 60) begin
        held = 1;
        hold = 150;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    eorq_pkg::mode_e   m;
    eorq_pkg::button_e btn;
    int                r;
    rst_ni              <= 1'b0;
    in_valid_i          <= 1'b0;
    mode_i              <= eorq_pkg::MODE_PLACE;
    floor_i             <= '0;
    button_i            <= eorq_pkg::BTN_UP;
    current_floor_i     <= '0;
    destination_floor_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // from empty tables: the first scan falls through to the destination
    send_request(eorq_pkg::MODE_SCAN_UP, 2'd0, eorq_pkg::BTN_UP, 2'd0, 2'd3);
    send_request(eorq_pkg::MODE_PLACE, 2'd0, eorq_pkg::BTN_UP, 2'd3, 2'd0);
    send_request(eorq_pkg::MODE_PLACE, 2'd3, eorq_pkg::BTN_DOWN, 2'd0, 2'd3);
    send_request(eorq_pkg::MODE_PLACE, 2'd2, eorq_pkg::BTN_CAB, 2'd1, 2'd2);
    send_request(eorq_pkg::MODE_PLACE, 2'd1, eorq_pkg::BTN_NONE, 2'd2, 2'd1);
    send_request(eorq_pkg::MODE_PLACE, 2'd0, eorq_pkg::BTN_UP, 2'd3, 2'd3);
    send_request(eorq_pkg::MODE_SCAN_UP, 2'd3, eorq_pkg::BTN_CAB, 2'd0, 2'd3);
    send_request(eorq_pkg::MODE_SCAN_DOWN, 2'd0, eorq_pkg::BTN_UP, 2'd3, 2'd0);
    send_request(eorq_pkg::MODE_SCAN_UP, 2'd1, eorq_pkg::BTN_DOWN, 2'd2, 2'd2);
    send_request(eorq_pkg::MODE_SCAN_DOWN, 2'd2, eorq_pkg::BTN_CAB, 2'd0, 2'd3);
    // fill every slot
    send_request(eorq_pkg::MODE_PLACE, 2'd1, eorq_pkg::BTN_UP, 2'd0, 2'd0);
    send_request(eorq_pkg::MODE_PLACE, 2'd2, eorq_pkg::BTN_UP, 2'd0, 2'd0);
    send_request(eorq_pkg::MODE_PLACE, 2'd3, eorq_pkg::BTN_UP, 2'd0, 2'd0);
    send_request(eorq_pkg::MODE_PLACE, 2'd0, eorq_pkg::BTN_DOWN, 2'd0, 2'd0);
    send_request(eorq_pkg::MODE_PLACE, 2'd1, eorq_pkg::BTN_DOWN, 2'd0, 2'd0);
    send_request(eorq_pkg::MODE_PLACE, 2'd2, eorq_pkg::BTN_DOWN, 2'd0, 2'd0);
    send_request(eorq_pkg::MODE_PLACE, 2'd0, eorq_pkg::BTN_CAB, 2'd0, 2'd0);
    send_request(eorq_pkg::MODE_PLACE, 2'd1, eorq_pkg::BTN_CAB, 2'd0, 2'd0);
    send_request(eorq_pkg::MODE_PLACE, 2'd3, eorq_pkg::BTN_CAB, 2'd0, 2'd0);
    send_request(eorq_pkg::MODE_PLACE, 2'd3, eorq_pkg::BTN_CAB, 2'd0, 2'd0);
    // clear floor 0 with the oldest order, clear it again while empty, then clear floor 3
    send_request(eorq_pkg::MODE_CLEAR, 2'd0, eorq_pkg::BTN_UP, 2'd0, 2'd0);
    send_request(eorq_pkg::MODE_CLEAR, 2'd0, eorq_pkg::BTN_CAB, 2'd3, 2'd3);
    send_request(eorq_pkg::MODE_CLEAR, 2'd3, eorq_pkg::BTN_NONE, 2'd0, 2'd0);
    send_request(eorq_pkg::MODE_SCAN_UP, 2'd0, eorq_pkg::BTN_UP, 2'd0, 2'd3);
    send_request(eorq_pkg::MODE_SCAN_DOWN, 2'd0, eorq_pkg::BTN_UP, 2'd3, 2'd0);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == CALM_AFTER) calm = 1;
      r   = $urandom_range(0, 99);
      m   = (r < 45) ? eorq_pkg::MODE_PLACE : (r < 65) ? eorq_pkg::MODE_CLEAR :
            (r < 83) ? eorq_pkg::MODE_SCAN_UP : eorq_pkg::MODE_SCAN_DOWN;
      btn = ($urandom_range(0, 9) == 0) ? eorq_pkg::BTN_NONE :
            eorq_pkg::button_e'($urandom_range(0, 2));
      send_request(m, 2'($urandom_range(0, 3)), btn, 2'($urandom_range(0, 3)),
                   2'($urandom_range(0, 3)));
    end
    in_valid_i <= 1'b0;

    while (board.expected_status.size() != 0) @(posedge clk_i);
    repeat (FLOORS + 8) @(posedge clk_i);

    $display("Checked %0d results from %0d transactions: %0d place, %0d clear,",
             board.checked, accepted, mode_seen[0], mode_seen[1]);
    $display("%0d scan up, %0d scan down; peak order count %0d; input held off %0d cycles",
             mode_seen[2], mode_seen[3], board.peak_count, stalled_cycles);
    if (board.mismatches == 0 && board.expected_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/eorq_pkg.sv
rtl/elevator_order_rank_queue.sv
tb/testbench.sv
